@@ rtl/core/sha_pkg.sv @@
// SHA-256 package: round constants, initial hash values, datapath command/status types.
package sha_pkg;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;

    // fill sources for the block buffer
    typedef enum logic [1:0] {
        FILL_DATA = 2'd0,
        FILL_PAD  = 2'd1,
        FILL_ZERO = 2'd2,
        FILL_LEN  = 2'd3
    } t_fill;

    typedef struct packed {
        logic       wr;       // write one byte at fill pointer
        t_fill      src;
        logic [7:0] data;
        logic       cnt_msg;  // count a message byte
        logic       start;    // begin a compression
        logic       chain_init;
        logic       out_load; // latch next digest word
        logic [2:0] out_idx;
    } t_cmd;

    typedef struct packed {
        logic [5:0] fill;
        logic       busy;     // compression running
    } t_stat;

endpackage

@@ rtl/core/sha_datapath.sv @@
// SHA-256 datapath: block buffer, length counter, message schedule and round unit.
module sha_datapath
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic [31:0] o_word
);

    // block buffer as 16 big-endian words, written one byte lane at a time
    logic [31:0] r_buf [16];
    logic [5:0]  r_fill;
    logic [60:0] r_msg;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [6:0]  r_rnd;
    logic        r_busy;
    logic        r_load;     // loading schedule words from buffer
    logic [3:0]  r_ld;

    logic [63:0] bits;
    logic [7:0]  wbyte;
    logic [31:0] s0, s1, wnext, wt, t1, t2, e, a;
    logic [5:0]  rt;

    assign bits = {r_msg, 3'b000};

    always_comb begin
        case (i_cmd.src)
            FILL_DATA: wbyte = i_cmd.data;
            FILL_PAD:  wbyte = PAD_BYTE;
            FILL_ZERO: wbyte = '0;
            FILL_LEN:  wbyte = bits[8*(7-32'(r_fill[2:0])) +: 8];
            default:   wbyte = '0;
        endcase
    end

    assign rt = r_rnd[5:0];
    assign s0 = {r_w[1][6:0], r_w[1][31:7]} ^ {r_w[1][17:0], r_w[1][31:18]} ^ (r_w[1] >> 3);
    assign s1 = {r_w[14][16:0], r_w[14][31:17]} ^ {r_w[14][18:0], r_w[14][31:19]}
              ^ (r_w[14] >> 10);
    assign wnext = r_w[0] + s0 + r_w[9] + s1;
    assign wt = r_w[0];
    assign e = r_v[4];
    assign a = r_v[0];
    assign t1 = r_v[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
              + ((e & r_v[5]) ^ (~e & r_v[6])) + ROUND_K[rt] + wt;
    assign t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
              + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_buf[r_fill[5:2]][8*(3-32'(r_fill[1:0])) +: 8] <= wbyte;
        end
        if (r_load) begin
            r_w[15] <= r_buf[r_ld];
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
        end else if (r_busy) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= wnext;
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
        if (i_cmd.start) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end
        if (i_cmd.out_load) begin
            o_word <= r_h[i_cmd.out_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_msg  <= '0;
            r_busy <= 1'b0;
            r_load <= 1'b0;
            r_ld   <= '0;
            r_rnd  <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= H_INIT[i];
        end else begin
            if (i_cmd.wr) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.cnt_msg) begin
                r_msg <= r_msg + 61'd1;
            end
            if (i_cmd.start) begin
                r_load <= 1'b1;
                r_ld   <= '0;
                r_rnd  <= '0;
            end else if (r_load) begin
                r_ld <= r_ld + 4'd1;
                if (r_ld == 4'd15) begin
                    r_load <= 1'b0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rnd <= r_rnd + 7'd1;
                if (r_rnd == 7'd63) begin
                    r_busy <= 1'b0;
                end
            end
            // fold working vars into chain in the cycle after the last round
            if (!r_busy && !r_load && r_rnd == 7'd64) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                r_rnd <= '0;
            end
            if (i_cmd.chain_init) begin
                for (int i = 0; i < 8; i++) r_h[i] <= H_INIT[i];
                r_msg  <= '0;
                r_fill <= '0;
            end
        end
    end

    assign o_stat.fill = r_fill;
    assign o_stat.busy = r_busy | r_load | (r_rnd == 7'd64);

    ap_fill_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr && i_cmd.src == FILL_LEN) |-> r_fill >= LEN_START)
        else $error("length byte outside tail");
    ap_no_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_load || r_busy) |-> !i_cmd.wr)
        else $error("buffer written during compression");
    ap_rnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_rnd < 7'd64)
        else $error("round counter overrun");

endmodule

@@ rtl/core/sha_ctrl.sv @@
// SHA-256 controller: input handshake, padding sequence, compress launch, digest output.
module sha_ctrl
    import sha_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_data_byte,
    input  logic       i_byte_valid,
    input  logic       i_is_last,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output logic       o_word_last,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_WAIT = 7'b0000010,  // compress after a full data block
        ST_PAD  = 7'b0000100,
        ST_ZERO = 7'b0001000,
        ST_LEN  = 7'b0010000,
        ST_FIN  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic       r_last, n_last;     // padding pending after a compress
    logic       r_padded, n_padded; // 0x80 already written
    logic [3:0] r_oi, n_oi;
    logic       r_ov, n_ov;
    logic       r_ol, n_ol;
    logic       acc;

    assign acc = i_valid && o_ready;
    assign o_ready = (r_state == ST_IDLE) && !i_stat.busy;
    assign o_out_valid = r_ov;
    assign o_word_last = r_ol;

    always_comb begin
        n_state  = r_state;
        n_last   = r_last;
        n_padded = r_padded;
        n_oi     = r_oi;
        n_ov     = r_ov;
        n_ol     = r_ol;
        o_cmd    = '0;
        o_cmd.data = i_data_byte;
        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    n_last = i_is_last;
                    if (i_byte_valid) begin
                        o_cmd.wr = 1'b1;
                        o_cmd.src = FILL_DATA;
                        o_cmd.cnt_msg = 1'b1;
                        if (i_stat.fill == 6'd63) begin
                            o_cmd.start = 1'b1;
                            n_state = ST_WAIT;
                        end else if (i_is_last) begin
                            n_state = ST_PAD;
                        end
                    end else if (i_is_last) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_WAIT: begin
                if (!i_stat.busy) begin
                    n_state = r_last ? ST_PAD : ST_IDLE;
                end
            end
            ST_PAD: begin
                if (!i_stat.busy) begin
                    if (!r_padded) begin
                        o_cmd.wr = 1'b1;
                        o_cmd.src = FILL_PAD;
                        n_padded = 1'b1;
                        if (i_stat.fill == 6'd63) begin
                            o_cmd.start = 1'b1;
                        end
                    end else begin
                        n_state = ST_ZERO;
                    end
                end
            end
            ST_ZERO: begin
                if (!i_stat.busy) begin
                    if (i_stat.fill == LEN_START) begin
                        n_state = ST_LEN;
                    end else begin
                        o_cmd.wr = 1'b1;
                        o_cmd.src = FILL_ZERO;
                        if (i_stat.fill == 6'd63) begin
                            o_cmd.start = 1'b1;
                        end
                    end
                end
            end
            ST_LEN: begin
                o_cmd.wr = 1'b1;
                o_cmd.src = FILL_LEN;
                if (i_stat.fill == 6'd63) begin
                    o_cmd.start = 1'b1;
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!i_stat.busy) begin
                    n_state = ST_OUT;
                    n_oi = '0;
                end
            end
            ST_OUT: begin
                if (!r_ov || i_out_ready) begin
                    if (r_oi == 4'd8) begin
                        o_cmd.chain_init = 1'b1;
                        n_state  = ST_IDLE;
                        n_padded = 1'b0;
                        n_last   = 1'b0;
                    end else begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_idx = r_oi[2:0];
                        n_ov = 1'b1;
                        n_ol = (r_oi == 4'd7);
                        n_oi = r_oi + 4'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_last   <= 1'b0;
            r_padded <= 1'b0;
            r_oi     <= '0;
            r_ov     <= 1'b0;
            r_ol     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_last   <= n_last;
            r_padded <= n_padded;
            r_oi     <= n_oi;
            r_ov     <= n_ov;
            r_ol     <= n_ol;
        end
    end

    ap_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !r_ov)
        else $error("input taken while digest pending");
    ap_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ol && i_out_ready) |=> !r_ov)
        else $error("word after last digest word");
    ap_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");

endmodule

@@ rtl/core/sha256_stream_hasher.sv @@
// SHA-256 streaming hasher top level: controller plus datapath.
//
//  channel | dir | handshake                    | payload
//  input   | in  | i_valid / o_ready            | i_data_byte, i_byte_valid, i_is_last
//  output  | out | o_out_valid / i_out_ready    | o_digest_word, o_word_last
//
// A message byte is written to the block buffer when accepted; every 64th byte
// starts a compression that loads the schedule words, runs the rounds and folds
// the working variables into the chain, and the input stalls until it is done.
// A last byte adds padding writes, one or two compressions, then 8 words.
// Reset is synchronous, active low, and loads the initial hash values.
// Output stalls hold the digest word; input waits while a block compresses.
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_is_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic        o_word_last
);

    t_cmd  cmd;
    t_stat stat;

    sha_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_data_byte  (i_data_byte),
        .i_byte_valid (i_byte_valid),
        .i_is_last    (i_is_last),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_word_last  (o_word_last),
        .i_stat       (stat),
        .o_cmd        (cmd)
    );

    sha_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_word  (o_digest_word)
    );

endmodule
